// File: src/sem_pkg.sv
// sem_pkg: shared widths, constants and pipeline types of the sobel edge magnitude unit
// no dependencies; imported by every module under src

package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int ROW_W      = CFG_H_W + 1;
    localparam int GRAD_W     = 11;
    localparam int SUM_W      = 16;
    localparam int ROOT_STEPS = 8;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_H_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [PIX_W-1:0]   MAG_SAT    = 8'hFF;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // which window rows and columns fall outside the frame
    typedef struct packed {
        logic row0;
        logic row2;
        logic col0;
        logic col2;
    } t_border;

    typedef struct packed {
        logic valid;
        logic last;
    } t_pipe_ctl;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             col_start;
        logic             emit;
        logic             last;
        t_border          border;
    } t_win_ctl;

endpackage

// File: src/sem_line_store.sv
// sem_line_store: single-port-write line memory holding {upper, middle} rows per column
// registered read with write-to-read forwarding; uses sem_pkg

module sem_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [2*sem_pkg::PIX_W-1:0]   i_wr_data,
    output logic [2*sem_pkg::PIX_W-1:0]   o_rd_data
);
    import sem_pkg::*;

    logic [2*PIX_W-1:0] r_mem [DEPTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [2*PIX_W-1:0] r_fwd_data;
    logic               r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
            if (i_wr_en) begin
                r_mem[i_wr_addr] <= i_wr_data;
            end
        end
    end

    // a read of the entry being written in the same cycle takes the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule

// File: src/sem_gradient.sv
// sem_gradient: 3x3 window, border masking, sobel sums and squared magnitude
// two register stages after the window; uses sem_pkg

module sem_gradient (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  sem_pkg::t_win_ctl           i_ctl,
    input  logic [sem_pkg::PIX_W-1:0]   i_upper,
    input  logic [sem_pkg::PIX_W-1:0]   i_middle,
    output sem_pkg::t_pipe_ctl          o_ctl,
    output logic                        o_sat,
    output logic [sem_pkg::SUM_W-1:0]   o_sum
);
    import sem_pkg::*;

    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] n_win [3][3];
    logic [PIX_W-1:0] p     [3][3];
    logic [PIX_W-1:0] col_new [3];

    logic [PIX_W+1:0]         sum_top, sum_bot, sum_rgt, sum_lft;
    logic signed [GRAD_W-1:0] gx, gy;
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    t_pipe_ctl                r_ctl_g, r_ctl_s;

    logic signed [2*GRAD_W-1:0] sq_x, sq_y;
    logic [2*GRAD_W-1:0]        sq_sum;
    logic                       r_sat;
    logic [SUM_W-1:0]           r_sum;

    always_comb begin
        col_new[0] = i_upper;
        col_new[1] = i_middle;
        col_new[2] = i_ctl.pixel;
        for (int r = 0; r < 3; r++) begin
            // start of a row: the window sees a zero column, then the new one lands after it
            p[r][0]     = r_win[r][1];
            p[r][1]     = r_win[r][2];
            p[r][2]     = i_ctl.col_start ? '0 : col_new[r];
            n_win[r][0] = i_ctl.col_start ? r_win[r][2] : r_win[r][1];
            n_win[r][1] = i_ctl.col_start ? '0 : r_win[r][2];
            n_win[r][2] = col_new[r];
        end
        for (int c = 0; c < 3; c++) begin
            if (i_ctl.border.row0) begin
                p[0][c] = '0;
            end
            if (i_ctl.border.row2) begin
                p[2][c] = '0;
            end
        end
        for (int r = 0; r < 3; r++) begin
            if (i_ctl.border.col0) begin
                p[r][0] = '0;
            end
            if (i_ctl.border.col2) begin
                p[r][2] = '0;
            end
        end
    end

    assign sum_top = {2'b00, p[0][0]} + {1'b0, p[0][1], 1'b0} + {2'b00, p[0][2]};
    assign sum_bot = {2'b00, p[2][0]} + {1'b0, p[2][1], 1'b0} + {2'b00, p[2][2]};
    assign sum_rgt = {2'b00, p[0][2]} + {1'b0, p[1][2], 1'b0} + {2'b00, p[2][2]};
    assign sum_lft = {2'b00, p[0][0]} + {1'b0, p[1][0], 1'b0} + {2'b00, p[2][0]};

    assign gx = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
    assign gy = $signed({1'b0, sum_rgt}) - $signed({1'b0, sum_lft});

    assign sq_x   = r_gx * r_gx;
    assign sq_y   = r_gy * r_gy;
    assign sq_sum = $unsigned(sq_x) + $unsigned(sq_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
            r_ctl_g <= '0;
            r_ctl_s <= '0;
        end else if (i_en) begin
            if (i_valid) begin
                r_win <= n_win;
            end
            r_ctl_g.valid <= i_valid && i_ctl.emit;
            r_ctl_g.last  <= i_ctl.last;
            r_ctl_s       <= r_ctl_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx  <= gx;
            r_gy  <= gy;
            r_sat <= |sq_sum[2*GRAD_W-1:SUM_W];
            r_sum <= sq_sum[SUM_W-1:0];
        end
    end

    assign o_ctl = r_ctl_s;
    assign o_sat = r_sat;
    assign o_sum = r_sum;

endmodule

// File: src/sem_isqrt.sv
// sem_isqrt: pipelined integer square root, one result bit per stage, with saturation
// uses sem_pkg

module sem_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  sem_pkg::t_pipe_ctl          i_ctl,
    input  logic                        i_sat,
    input  logic [sem_pkg::SUM_W-1:0]   i_sum,
    output sem_pkg::t_pipe_ctl          o_ctl,
    output logic [sem_pkg::PIX_W-1:0]   o_root
);
    import sem_pkg::*;

    localparam int RW = SUM_W + 1;

    t_pipe_ctl       r_ctl [1:ROOT_STEPS];
    logic            r_sat [1:ROOT_STEPS];
    logic [RW-1:0]   r_rem [1:ROOT_STEPS];
    logic [RW-1:0]   r_res [1:ROOT_STEPS];
    logic [RW-1:0]   n_rem [1:ROOT_STEPS];
    logic [RW-1:0]   n_res [1:ROOT_STEPS];

    always_comb begin
        logic [RW-1:0] rem_in;
        logic [RW-1:0] res_in;
        logic [RW-1:0] trial;
        logic [RW-1:0] bit_k;
        for (int k = 0; k < ROOT_STEPS; k++) begin
            if (k == 0) begin
                rem_in = RW'(i_sum);
                res_in = '0;
            end else begin
                rem_in = r_rem[k];
                res_in = r_res[k];
            end
            bit_k = RW'(1) << (2 * (ROOT_STEPS - 1 - k));
            trial = res_in + bit_k;
            if (rem_in >= trial) begin
                n_rem[k+1] = rem_in - trial;
                n_res[k+1] = (res_in >> 1) + bit_k;
            end else begin
                n_rem[k+1] = rem_in;
                n_res[k+1] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= ROOT_STEPS; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[1] <= i_ctl;
            for (int k = 2; k <= ROOT_STEPS; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[1] <= i_sat;
            for (int k = 2; k <= ROOT_STEPS; k++) begin
                r_sat[k] <= r_sat[k-1];
            end
            for (int k = 1; k <= ROOT_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_ctl  = r_ctl[ROOT_STEPS];
    assign o_root = r_sat[ROOT_STEPS] ? MAG_SAT : r_res[ROOT_STEPS][PIX_W-1:0];

endmodule

// File: src/sobel_edge_magnitude_unit.sv
// sobel_edge_magnitude_unit: top level, position counters, config registers, output register
// uses sem_pkg, sem_line_store, sem_gradient, sem_isqrt
//
//   port group   dir   handshake                    payload
//   in           in    i_in_valid / o_in_ready      i_pixel, i_pad
//   out          out   o_out_valid / i_out_ready    o_magnitude, o_last_of_frame
//   cfg (apb)    in    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one item per cycle while the output is not stalled; a result passes the accept register,
// gradient with window shift, squares, 8 root stages and the output register (the line memory
// read happens at the accepting edge)
// the line memory needs no clearing pass after reset; config takes effect at once
// when the output register holds an untaken result, the whole pipeline stalls

module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sem_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_pad,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sem_pkg::PIX_W-1:0]     o_magnitude,
    output logic                          o_last_of_frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sem_pkg::APB_AW-1:0]    paddr,
    input  logic [sem_pkg::APB_DW-1:0]    pwdata,
    output logic [sem_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W_W) ? $clog2(MAX_WIDTH + 1) : CFG_W_W;

    logic [CFG_W_W-1:0] r_width;
    logic [CFG_H_W-1:0] r_height;
    logic [AW-1:0]      r_in_col,  n_in_col;
    logic [ROW_W-1:0]   r_in_row,  n_in_row;
    logic [AW-1:0]      r_out_col, n_out_col;
    logic [CFG_H_W-1:0] r_out_row, n_out_row;

    logic               r_b_valid;
    t_win_ctl           r_b_ctl;
    logic [AW-1:0]      r_b_addr;

    logic               r_out_valid;
    logic               r_out_last;
    logic [PIX_W-1:0]   r_out_mag;

    logic               en;
    logic               accept;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic [WW-1:0]      w_eff;
    logic [CFG_H_W-1:0] h_eff;
    logic [WW-1:0]      in_col_inc;
    logic [WW-1:0]      out_col_inc;
    logic [ROW_W-1:0]   out_row_inc;
    logic               in_wrap;
    logic               out_col_end;
    logic               out_row_end;
    logic               emit;
    logic               last;
    t_win_ctl           a_ctl;

    logic [2*PIX_W-1:0] rd_data;
    logic [2*PIX_W-1:0] wr_data;
    t_pipe_ctl          grad_ctl;
    logic               grad_sat;
    logic [SUM_W-1:0]   grad_sum;
    t_pipe_ctl          root_ctl;
    logic [PIX_W-1:0]   root_val;

    assign en     = !r_out_valid || i_out_ready;
    assign accept = i_in_valid && en;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        if (r_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height == '0) ? CFG_H_W'(1) : r_height;
    end

    assign in_col_inc  = WW'(r_in_col) + WW'(1);
    assign in_wrap     = in_col_inc >= w_eff;
    assign out_col_inc = WW'(r_out_col) + WW'(1);
    assign out_col_end = out_col_inc >= w_eff;
    assign out_row_inc = ROW_W'(r_out_row) + ROW_W'(1);
    assign out_row_end = out_row_inc >= ROW_W'(h_eff);

    // results start one row plus one pixel into the frame
    assign emit = (r_in_row >= ROW_W'(2)) || ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
    assign last = emit && out_row_end && out_col_end;

    always_comb begin
        a_ctl.pixel       = i_pad ? '0 : i_pixel;
        a_ctl.col_start   = (r_in_col == '0);
        a_ctl.emit        = emit;
        a_ctl.last        = last;
        a_ctl.border.row0 = (r_out_row == '0);
        a_ctl.border.row2 = out_row_end;
        a_ctl.border.col0 = (r_out_col == '0);
        a_ctl.border.col2 = out_col_end;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (accept) begin
            n_in_col = in_wrap ? '0 : in_col_inc[AW-1:0];
            n_in_row = r_in_row + ROW_W'(in_wrap);
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (emit) begin
                n_out_col = out_col_end ? '0 : out_col_inc[AW-1:0];
                n_out_row = r_out_row + CFG_H_W'(out_col_end);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_IMAGE_WIDTH:  r_width  <= pwdata[CFG_W_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= pwdata[CFG_H_W-1:0];
                    default: ;
                endcase
            end
            if (en) begin
                r_b_valid   <= accept;
                r_out_valid <= root_ctl.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ctl    <= a_ctl;
            r_b_addr   <= r_in_col;
            r_out_last <= root_ctl.last;
            r_out_mag  <= root_val;
        end
    end

    // old middle row moves up, the new pixel becomes the middle row
    assign wr_data = {rd_data[PIX_W-1:0], r_b_ctl.pixel};

    sem_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_rd_addr (r_in_col),
        .i_wr_en   (r_b_valid),
        .i_wr_addr (r_b_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    sem_gradient u_gradient (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_b_valid),
        .i_ctl    (r_b_ctl),
        .i_upper  (rd_data[2*PIX_W-1:PIX_W]),
        .i_middle (rd_data[PIX_W-1:0]),
        .o_ctl    (grad_ctl),
        .o_sat    (grad_sat),
        .o_sum    (grad_sum)
    );

    sem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (grad_ctl),
        .i_sat   (grad_sat),
        .i_sum   (grad_sum),
        .o_ctl   (root_ctl),
        .o_root  (root_val)
    );

    assign o_in_ready      = en;
    assign o_out_valid     = r_out_valid;
    assign o_magnitude     = r_out_mag;
    assign o_last_of_frame = r_out_last;
    assign pready          = 1'b1;
    assign prdata          = (cfg_idx == REG_IMAGE_HEIGHT) ? APB_DW'(r_height)
                                                           : APB_DW'(r_width);

endmodule

// File: tb/sv/tb_sobel_edge_magnitude_unit.sv
// testbench for sobel_edge_magnitude_unit: random pixel frames against a cycle-free gradient predictor
// depends on sem_pkg and the rtl under src; drives the pixel, result and apb config ports

module tb_sobel_edge_magnitude_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 350;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             pad;
    } pixel_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             last_of_frame;
    } mag_result_t;

    typedef enum int {FRAME_CLEAN, FRAME_NOISY, FRAME_BROKEN} frame_kind_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_STALLS, RX_MOSTLY} rx_mode_e;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [PIX_W-1:0]     i_pixel = '0;
    logic                 i_pad = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [PIX_W-1:0]     o_magnitude;
    logic                 o_last_of_frame;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    sobel_edge_magnitude_unit #(
        .MAX_WIDTH(MAX_W)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel         (i_pixel),
        .i_pad           (i_pad),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_magnitude     (o_magnitude),
        .o_last_of_frame (o_last_of_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // stimulus and expectations
    pixel_item_t pending_pixels[$];
    mag_result_t expected_mags[$];
    int unsigned issued_items = 0;
    int unsigned accepted_items = 0;
    int unsigned mismatch_count = 0;
    logic        in_taken = 1'b0;

    // predictor state
    logic [CFG_W_W-1:0] width_cfg = WIDTH_RST;
    logic [CFG_H_W-1:0] height_cfg = HEIGHT_RST;
    logic [PIX_W-1:0]   upper_line [MAX_W];
    logic [PIX_W-1:0]   middle_line [MAX_W];
    logic [PIX_W-1:0]   win [3][3];
    int                 in_col = 0;
    int                 in_row = 0;
    int                 out_col = 0;
    int                 out_row = 0;

    // sender and receiver pacing
    int       burst_left = 1;
    int       gap_left = 0;
    rx_mode_e ready_mode = RX_OPEN;
    int       mode_left = 0;
    int       stall_left = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_width(logic [CFG_W_W-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_W) return MAX_W;
        return int'(w);
    endfunction

    function automatic int eff_height(logic [CFG_H_W-1:0] h);
        return (h == 0) ? 1 : int'(h);
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // window column 2 is the newest
    function automatic void shift_column(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                                         logic [PIX_W-1:0] bot);
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = bot;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endtask

    // one accepted item in, zero or one expected magnitude out
    task automatic sobel_predict(input logic [PIX_W-1:0] pix, input logic pad);
        int          ew, eh, ic, idx, gx, gy;
        int          p [3][3];
        int unsigned sq, root, trial;
        logic [PIX_W-1:0] v, up, md;
        bit          emit, last;
        mag_result_t res;
        ew = eff_width(width_cfg);
        eh = eff_height(height_cfg);
        ic = in_col;
        idx = (ic < MAX_W) ? ic : 0;
        v = pad ? 8'd0 : pix;
        up = upper_line[idx];
        md = middle_line[idx];
        emit = (in_row >= 2) || (in_row == 1 && ic >= 1);
        last = 1'b0;
        if (ic == 0) shift_column(8'd0, 8'd0, 8'd0);
        else shift_column(up, md, v);
        if (emit) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p[r][c] = int'(win[r][c]);
            // neighbours outside the frame read as zero
            if (out_row == 0) for (int c = 0; c < 3; c++) p[0][c] = 0;
            if (out_row + 1 >= eh) for (int c = 0; c < 3; c++) p[2][c] = 0;
            if (out_col == 0) for (int r = 0; r < 3; r++) p[r][0] = 0;
            if (out_col + 1 >= ew) for (int r = 0; r < 3; r++) p[r][2] = 0;
            gx = (p[0][0] + 2 * p[0][1] + p[0][2]) - (p[2][0] + 2 * p[2][1] + p[2][2]);
            gy = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
            sq = int'(gx * gx) + int'(gy * gy);
            if (sq >= 65536) begin
                root = MAG_SAT;
            end else begin
                root = 0;
                for (int b = 7; b >= 0; b--) begin
                    trial = root | (1 << b);
                    if (trial * trial <= sq) root = trial;
                end
            end
            last = (out_row + 1 >= eh) && (out_col + 1 >= ew);
            res.magnitude = root[PIX_W-1:0];
            res.last_of_frame = last;
            expected_mags.push_back(res);
        end
        if (ic == 0) shift_column(up, md, v);
        upper_line[idx] = md;
        middle_line[idx] = v;
        in_col = ic + 1;
        if (in_col >= ew) begin
            in_col = 0;
            in_row++;
        end
        if (emit) begin
            if (last) begin
                restart_frame();
            end else begin
                out_col++;
                if (out_col >= ew) begin
                    out_col = 0;
                    out_row++;
                end
            end
        end
    endtask

    // result check first, then prediction, in one process so the queue sees a fixed order
    always @(posedge i_clk) begin
        mag_result_t want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_mags.size() == 0) begin
                    report_mismatch("result with none expected", o_magnitude, 0);
                end else begin
                    want = expected_mags.pop_front();
                    if (o_magnitude !== want.magnitude)
                        report_mismatch("magnitude", o_magnitude, want.magnitude);
                    if (o_last_of_frame !== want.last_of_frame)
                        report_mismatch("last_of_frame", o_last_of_frame, want.last_of_frame);
                end
            end
            if (i_in_valid && o_in_ready) begin
                accepted_items++;
                sobel_predict(i_pixel, i_pad);
            end
            in_taken <= i_in_valid && o_in_ready;
        end
    end

    // pixel driver: bursts of items with random gaps
    always @(negedge i_clk) begin
        pixel_item_t cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // hold the item until it is taken
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_pixels.size() > 0) begin
            cur = pending_pixels.pop_front();
            i_in_valid <= 1'b1;
            i_pixel <= cur.pixel;
            i_pad <= cur.pad;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result receiver: stall pattern switches among four randomly chosen modes
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= rx_mode_e'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 96);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RX_OPEN: i_out_ready <= 1'b1;
            RX_COIN: i_out_ready <= 1'($urandom_range(0, 1));
            RX_STALLS: begin
                if (stall_left > 0) begin
                    i_out_ready <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
                end
            end
            default: i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_IMAGE_WIDTH) width_cfg = data[CFG_W_W-1:0];
        else height_cfg = data[CFG_H_W-1:0];
        restart_frame();
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input t_reg_idx idx, input logic [APB_DW-1:0] want);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] pix, input logic pad);
        pixel_item_t item;
        item.pixel = pix;
        item.pad = pad;
        pending_pixels.push_back(item);
        issued_items++;
    endtask

    // a frame is width*height pixels followed by width+1 flush items, cut short when broken or by the limit
    task automatic queue_frame(input int ew, input int eh, input frame_kind_e kind,
                               input int limit);
        int   npix, count;
        logic pad;
        npix = ew * eh;
        count = npix + ew + 1;
        if (kind == FRAME_BROKEN) count = $urandom_range(1, count - 1);
        if (count > limit) count = limit;
        for (int i = 0; i < count; i++) begin
            if (i < npix) pad = (kind == FRAME_NOISY) && ($urandom_range(0, 5) == 0);
            else pad = !((kind == FRAME_NOISY) && ($urandom_range(0, 3) == 0));
            queue_pixel(rand_pixel(), pad);
        end
    endtask

    // block idle: every item taken, every result seen, pipeline emptied
    task automatic drain_pipeline();
        while (accepted_items != issued_items || expected_mags.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W_W-1:0] w, input logic [CFG_H_W-1:0] h,
                             input int frames, input int limit, input bit mixed);
        logic [APB_DW-1:0] wdata, hdata;
        int               r;
        frame_kind_e      kind;
        drain_pipeline();
        // upper bits are random and must be dropped by the register
        wdata = $urandom();
        wdata[CFG_W_W-1:0] = w;
        hdata = $urandom();
        hdata[CFG_H_W-1:0] = h;
        if ($urandom_range(0, 1)) begin
            apb_write(REG_IMAGE_WIDTH, wdata);
            apb_write(REG_IMAGE_HEIGHT, hdata);
        end else begin
            apb_write(REG_IMAGE_HEIGHT, hdata);
            apb_write(REG_IMAGE_WIDTH, wdata);
        end
        apb_read_check(REG_IMAGE_WIDTH, APB_DW'(w));
        apb_read_check(REG_IMAGE_HEIGHT, APB_DW'(h));
        for (int f = 0; f < frames; f++) begin
            kind = FRAME_CLEAN;
            if (mixed) begin
                r = $urandom_range(0, 9);
                if (r == 0) kind = FRAME_BROKEN;
                else if (r <= 3) kind = FRAME_NOISY;
            end
            queue_frame(eff_width(w), eff_height(h), kind, limit);
        end
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int                 random_items, start;
        logic [CFG_W_W-1:0] w;
        logic [CFG_H_W-1:0] h;
        for (int i = 0; i < MAX_W; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(REG_IMAGE_WIDTH, APB_DW'(WIDTH_RST));
        apb_read_check(REG_IMAGE_HEIGHT, APB_DW'(HEIGHT_RST));

        // checkerboard 3x3: saturated and zero gradients, every border
        run_phase(11'd3, 13'd3, 0, 0, 1'b0);
        for (int i = 0; i < 9; i++) queue_pixel((i % 2) ? 8'h00 : 8'hFF, 1'b0);
        for (int i = 0; i < 4; i++) queue_pixel(8'hA5, 1'b1);
        // a bright row with a pad inside above a dark row; pads carry a pixel that must be dropped
        run_phase(11'd4, 13'd2, 0, 0, 1'b0);
        queue_pixel(8'hFF, 1'b0);
        queue_pixel(8'hFF, 1'b0);
        queue_pixel(8'hFF, 1'b1);
        queue_pixel(8'hFF, 1'b0);
        for (int i = 0; i < 4; i++) queue_pixel(8'h00, 1'b0);
        for (int i = 0; i < 5; i++) queue_pixel(8'hFF, 1'b1);

        // size extremes: zero acts as one, a width above MAX_W is held by the register but clamped in use
        run_phase(11'd0, 13'd0, 2, 1 << 30, 1'b0);
        run_phase(11'd2047, 13'd2, 0, 0, 1'b0);
        run_phase(11'd1, 13'd4096, 1, 40, 1'b0);
        run_phase(11'd5, 13'd8191, 1, 40, 1'b0);
        run_phase(11'd1, 13'd1, 3, 1 << 30, 1'b1);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 7) == 0) ? CFG_W_W'($urandom_range(11, 40))
                                            : CFG_W_W'($urandom_range(1, 10));
            h = CFG_H_W'($urandom_range(1, 6));
            start = issued_items;
            run_phase(w, h, $urandom_range(1, 3), 1 << 30, 1'b1);
            random_items += issued_items - start;
        end

        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sobel_edge_magnitude_unit.f
src/sem_pkg.sv
src/sem_line_store.sv
src/sem_gradient.sv
src/sem_isqrt.sv
src/sobel_edge_magnitude_unit.sv
tb/sv/tb_sobel_edge_magnitude_unit.sv
